@@ hdl/s2d_pkg.sv @@
// Shared constants and types for the signed integer to decimal text converter.
package s2d_pkg;

  // Field widths.
  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 8;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BCD_W      = NUM_DIGITS * DIGIT_W;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  // Character codes.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;

  // Converted value handed from the converter to the character emitter.
  typedef struct packed {
    logic             negative;
    logic [BCD_W-1:0] bcd;
  } bcd_word_t;

endpackage

@@ hdl/s2d_in_if.sv @@
// Input channel: one signed value per beat.
interface s2d_in_if
  import s2d_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ hdl/s2d_out_if.sv @@
// Output channel: one ASCII character per beat, with a last flag.
interface s2d_out_if
  import s2d_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] ascii_char;
  logic              last;

  modport source (output valid, output ascii_char, output last, input ready);
  modport sink (input valid, input ascii_char, input last, output ready);
endinterface

@@ hdl/signed_int_to_decimal_ascii_core.sv @@
// Top level: signed 32-bit integer to decimal ASCII text, bit-serial conversion.
//
//   Channel  Direction  Beat payload               Notes
//   in_ch    sink       value (signed 32 bits)     one value per beat
//   out_ch   source     ascii_char (8), last (1)   1 to 11 beats per value
//
// The converter accepts a value, runs 32 shift-and-add-3 steps of one magnitude bit each,
// and then holds the digits until the emitter takes them. The emitter drops leading
// zeros one at a time and then sends the sign and digits one character per beat; it
// works while the next value converts, so a new value is taken once the digits are handed
// over, even while the emitter is still sending the previous one.
// Reset is asynchronous and clears only the sequencers. Output stalls hold the current
// character; the input is refused while a converted value waits for the emitter.
module signed_int_to_decimal_ascii_core
  import s2d_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  s2d_in_if.sink   in_ch,
  s2d_out_if.source out_ch
);

  logic      conv_idle;
  logic      res_valid;
  logic      res_take;
  bcd_word_t res;

  assign in_ch.ready = conv_idle;

  // Binary to BCD conversion.
  s2d_dabble u_dabble (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_ch.valid),
    .value_i     (in_ch.value),
    .idle_o      (conv_idle),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Character output.
  s2d_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_take_o  (res_take),
    .out_ch      (out_ch)
  );

  // A shown character is a minus sign or a decimal digit.
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid |-> (out_ch.ascii_char == CHAR_MINUS) ||
                     ((out_ch.ascii_char >= CHAR_ZERO) &&
                      (out_ch.ascii_char <= CHAR_ZERO + CHAR_W'(DIGIT_MAX))))
    else $error("output character is neither a sign nor a digit");

  // The sign is never the final character.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && (out_ch.ascii_char == CHAR_MINUS)) |-> !out_ch.last)
    else $error("minus sign flagged as last character");

  // The output is idle in the cycle after the last beat of a value.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_ch.valid && out_ch.ready && out_ch.last) |=> !out_ch.valid)
    else $error("output beat directly after last character");

  // An accepted value keeps the converter busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted beat");

endmodule

@@ hdl/s2d_dabble.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one magnitude bit per cycle.
module s2d_dabble
  import s2d_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [VALUE_W-1:0] value_i,
  output logic                      idle_o,
  output logic                      res_valid_o,
  input  logic                      res_take_i,
  output bcd_word_t                 res_o
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_SHIFT = 3'b010,
    C_FULL  = 3'b100
  } conv_state_e;

  conv_state_e          state_q, state_d;
  logic [BIT_CNT_W-1:0] bit_cnt_q, bit_cnt_d;
  logic [VALUE_W-1:0]   mag_q, mag_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic                 neg_q, neg_d;
  logic [VALUE_W-1:0]   word;
  logic [BCD_W-1:0]     bcd_adj;

  // The input as an unsigned word; on load the most negative value has magnitude 2^31.
  assign word = VALUE_W'(value_i);

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_q[i*DIGIT_W +: DIGIT_W] > 4'd4) begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  // Sequencer: load, 32 shift steps, then hold the result until the emitter takes it.
  always_comb begin
    state_d   = state_q;
    bit_cnt_d = bit_cnt_q;
    mag_d     = mag_q;
    bcd_d     = bcd_q;
    neg_d     = neg_q;
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          neg_d     = word[VALUE_W-1];
          mag_d     = word[VALUE_W-1] ? (VALUE_W'(0) - word) : word;
          bcd_d     = '0;
          bit_cnt_d = '0;
          state_d   = C_SHIFT;
        end
      end
      C_SHIFT: begin
        {bcd_d, mag_d} = {bcd_adj[BCD_W-2:0], mag_q, 1'b0};
        bit_cnt_d      = bit_cnt_q + 1'b1;
        if (bit_cnt_q == BIT_CNT_W'(VALUE_W - 1)) begin
          state_d = C_FULL;
        end
      end
      C_FULL: begin
        if (res_take_i) begin
          state_d = C_IDLE;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= C_IDLE;
      bit_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      bit_cnt_q <= bit_cnt_d;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  assign idle_o         = (state_q == C_IDLE);
  assign res_valid_o    = (state_q == C_FULL);
  assign res_o.negative = neg_q;
  assign res_o.bcd      = bcd_q;

endmodule

@@ hdl/s2d_emit.sv @@
// Character emitter: drops leading zeros, then sends sign and digits one beat at a time.
module s2d_emit
  import s2d_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      res_valid_i,
  input  bcd_word_t res_i,
  output logic      res_take_o,
  s2d_out_if.source out_ch
);

  typedef enum logic [3:0] {
    E_IDLE  = 4'b0001,
    E_SKIP  = 4'b0010,
    E_SIGN  = 4'b0100,
    E_DIGIT = 4'b1000
  } emit_state_e;

  emit_state_e          state_q, state_d;
  logic [DIG_CNT_W-1:0] cnt_q, cnt_d;
  logic [BCD_W-1:0]     bcd_q, bcd_d;
  logic                 neg_q, neg_d;
  logic [DIGIT_W-1:0]   top_digit;
  logic                 one_left;

  assign top_digit  = bcd_q[BCD_W-1 -: DIGIT_W];
  assign one_left   = (cnt_q == DIG_CNT_W'(1));
  assign res_take_o = (state_q == E_IDLE) && res_valid_i;

  // Sequencer over the digit shift register.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    bcd_d   = bcd_q;
    neg_d   = neg_q;
    case (state_q)
      E_IDLE: begin
        if (res_valid_i) begin
          bcd_d   = res_i.bcd;
          neg_d   = res_i.negative;
          cnt_d   = DIG_CNT_W'(NUM_DIGITS);
          state_d = E_SKIP;
        end
      end
      E_SKIP: begin
        // Drop one leading zero per cycle, but always keep the final digit.
        if ((top_digit == '0) && !one_left) begin
          bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          cnt_d = cnt_q - 1'b1;
        end else begin
          state_d = neg_q ? E_SIGN : E_DIGIT;
        end
      end
      E_SIGN: begin
        if (out_ch.ready) begin
          state_d = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (out_ch.ready) begin
          if (one_left) begin
            state_d = E_IDLE;
          end else begin
            bcd_d = {bcd_q[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = E_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Digit shift register and sign.
  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    neg_q <= neg_d;
  end

  // Output beat, driven straight from the registers so it holds under a stall.
  always_comb begin
    out_ch.valid      = 1'b0;
    out_ch.ascii_char = CHAR_ZERO + CHAR_W'(top_digit);
    out_ch.last       = 1'b0;
    case (state_q)
      E_SIGN: begin
        out_ch.valid      = 1'b1;
        out_ch.ascii_char = CHAR_MINUS;
      end
      E_DIGIT: begin
        out_ch.valid = 1'b1;
        out_ch.last  = one_left;
      end
      default: begin
        out_ch.valid = 1'b0;
      end
    endcase
  end

endmodule

@@ dv/tb.sv @@
// Testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb;
  import s2d_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 11;
  localparam int NUM_DIRECTED = 20;
  localparam int NUM_RANDOM   = 290;
  localparam int TAIL_CYCLES  = 60;
  localparam int CYCLE_LIMIT  = 200_000;

  // One character beat as it should leave the block.
  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              last;
  } char_beat_t;

  // A directed value; an empty text means the digit predictor supplies it.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    string                     text;
  } directed_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  s2d_in_if  in_ch ();
  s2d_out_if out_ch ();

  signed_int_to_decimal_ascii_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_beat_t pending_chars[$];
  int         mismatch_count = 0;
  int         cycle_count    = 0;
  bit         source_steady  = 1'b0;
  bit         sink_steady    = 1'b0;

  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{32'sd0,             "0"},
    '{32'sd1,             "1"},
    '{-32'sd1,            "-1"},
    '{32'sd9,             "9"},
    '{32'sd10,            "10"},
    '{-32'sd10,           "-10"},
    '{32'sh7FFF_FFFF,     "2147483647"},
    '{32'sh8000_0000,     "-2147483648"},
    '{32'sh8000_0001,     "-2147483647"},
    '{32'sd99,            ""},
    '{32'sd100,           ""},
    '{-32'sd999,          ""},
    '{32'sd999_999_999,   ""},
    '{32'sd1_000_000_000, ""},
    '{-32'sd1_000_000_000, ""},
    '{32'sd12345,         ""},
    '{-32'sd54321,        ""},
    '{32'sh5555_5555,     ""},
    '{32'shAAAA_AAAA,     ""},
    '{32'sd7,             ""}
  };

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Decimal text of a two's complement word, built from its unsigned magnitude.
  function automatic string decimal_text(logic [VALUE_W-1:0] word);
    logic [VALUE_W-1:0] mag;
    string              text;
    mag  = word[VALUE_W-1] ? (~word + 1'b1) : word;
    text = "";
    do begin
      text = $sformatf("%c%s", CHAR_ZERO + CHAR_W'(mag % 10), text);
      mag  = mag / 10;
    end while (mag != 0);
    if (word[VALUE_W-1]) begin
      text = $sformatf("%c%s", CHAR_MINUS, text);
    end
    return text;
  endfunction

  // Queue one beat per character; the final one carries the last flag.
  function automatic void queue_text(string text);
    for (int i = 0; i < text.len(); i++) begin
      pending_chars.push_back('{ascii_char: text[i], last: (i == text.len() - 1)});
    end
  endfunction

  // Offer one value, after a random gap unless the source is steady, and hold it until the block takes it.
  task automatic send_value(logic signed [VALUE_W-1:0] value, string text);
    int gap;
    gap = source_steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    queue_text(text);
    if ($urandom_range(0, 24) == 0) source_steady = !source_steady;
  endtask

  // Stop offering values until every queued character has come out.
  task automatic drain_pending();
    in_ch.valid <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Reset, directed values, random values, then the final verdict.
  initial begin : stimulus
    logic signed [VALUE_W-1:0] value;
    logic [VALUE_W-1:0]        mag;
    logic [63:0]               span;
    int                        num_digits;
    rst_ni      = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      send_value(directed_rows[i].value,
                 directed_rows[i].text != "" ? directed_rows[i].text
                                             : decimal_text(directed_rows[i].value));
    end
    drain_pending();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // Mix full-range words, values of up to a chosen digit count, values around
      // powers of ten, and small values around zero.
      case ($urandom_range(0, 3))
        0: value = $urandom;
        1: begin
          num_digits = $urandom_range(1, 10);
          span = 64'd1;
          repeat (num_digits) span = span * 10;
          mag   = VALUE_W'(64'($urandom) % span);
          value = $urandom_range(0, 1) ? -mag : mag;
        end
        2: begin
          num_digits = $urandom_range(0, 9);
          span = 64'd1;
          repeat (num_digits) span = span * 10;
          mag   = span[VALUE_W-1:0] + VALUE_W'($urandom_range(0, 2)) - 1;
          value = $urandom_range(0, 1) ? -mag : mag;
        end
        default: value = VALUE_W'($urandom_range(0, 40)) - 20;
      endcase
      send_value(value, decimal_text(value));
      if (n == NUM_RANDOM / 2) drain_pending();
    end
    drain_pending();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Output side: stall at random unless the sink is steady, then compare each beat with the oldest expectation.
  initial begin : char_checker
    char_beat_t want;
    int         stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      if (pending_chars.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected beat, got char 0x%0h last %0b", $time,
                 out_ch.ascii_char, out_ch.last);
      end else begin
        want = pending_chars.pop_front();
        if (out_ch.ascii_char !== want.ascii_char) begin
          mismatch_count++;
          $display("%0t: ascii_char mismatch, expected 0x%0h got 0x%0h", $time,
                   want.ascii_char, out_ch.ascii_char);
        end
        if (out_ch.last !== want.last) begin
          mismatch_count++;
          $display("%0t: last mismatch, expected %0b got %0b", $time,
                   want.last, out_ch.last);
        end
      end
      if ($urandom_range(0, 39) == 0) sink_steady = !sink_steady;
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
